// ===== rtl/pde_pkg.sv =====
// ----------------------------------------------------------------------------
// pde_pkg - shared types and constants of the postfix digit evaluator
// Request formats, decoded command format, status codes and unit interfaces.
// ----------------------------------------------------------------------------
package pde_pkg;

  // Default operand stack depth (entries)
  localparam int STACK_DEPTH_DEF = 16;

  // Arithmetic width
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DATA_W + 1);

  // Command queue between front and back end (power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QAW         = $clog2(QUEUE_DEPTH);

  // ASCII codes of interest
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DIVZERO   = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_expr;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUSH,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] digit;
    logic       last;
  } cmd_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_EXEC,
    B_DIV,
    B_EMIT
  } back_state_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/pde_ram.sv =====
// ----------------------------------------------------------------------------
// pde_ram - generic single-write, single-read RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pde_ram #(
  parameter int WIDTH = pde_pkg::DATA_W,
  parameter int DEPTH = pde_pkg::STACK_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

// ===== rtl/pde_front.sv =====
// ----------------------------------------------------------------------------
// pde_front - request intake and character decode
// Accepts a character request, decodes it into a command and queues it.
// ----------------------------------------------------------------------------
module pde_front (
  input  pde_pkg::in_item_t in_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              q_full,
  output logic              q_wr,
  output pde_pkg::cmd_t     q_wdata
);

  function automatic pde_pkg::op_t decode_op(input logic [7:0] c);
    pde_pkg::op_t op;
    op = pde_pkg::OP_NOP;
    if (c >= pde_pkg::CH_ZERO && c <= pde_pkg::CH_NINE) begin
      op = pde_pkg::OP_PUSH;
    end else if (c == pde_pkg::CH_PLUS) begin
      op = pde_pkg::OP_ADD;
    end else if (c == pde_pkg::CH_MINUS) begin
      op = pde_pkg::OP_SUB;
    end else if (c == pde_pkg::CH_STAR) begin
      op = pde_pkg::OP_MUL;
    end else if (c == pde_pkg::CH_SLASH) begin
      op = pde_pkg::OP_DIV;
    end
    return op;
  endfunction

  logic [7:0] digit_full;

  // Hold off the source while the queue is full
  assign in_stall = q_full;
  assign q_wr     = in_valid && !q_full;

  assign digit_full    = in_data.char_code - pde_pkg::CH_ZERO;
  assign q_wdata.op    = decode_op(in_data.char_code);
  assign q_wdata.digit = digit_full[3:0];
  assign q_wdata.last  = in_data.end_of_expr;

endmodule

// ===== rtl/pde_fifo.sv =====
// ----------------------------------------------------------------------------
// pde_fifo - command queue between front and back end
// Small register queue; decouples intake from stack execution.
// ----------------------------------------------------------------------------
module pde_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  pde_pkg::cmd_t wdata,
  input  logic          rd,
  output pde_pkg::cmd_t rdata,
  output logic          full,
  output logic          empty
);

  pde_pkg::cmd_t            mem_r [pde_pkg::QUEUE_DEPTH];
  logic [pde_pkg::QAW-1:0]  wptr_r, wptr_nxt;
  logic [pde_pkg::QAW-1:0]  rptr_r, rptr_nxt;
  logic [pde_pkg::QAW:0]    count_r, count_nxt;
  logic                     do_wr, do_rd;

  assign full  = (count_r == (pde_pkg::QAW+1)'(pde_pkg::QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rptr_r];

  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;

  always_comb begin
    wptr_nxt  = do_wr ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = do_rd ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/pde_div.sv =====
// ----------------------------------------------------------------------------
// pde_div - iterative signed divider
// Restoring radix-2 divide on magnitudes, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module pde_div (
  input  logic              clk,
  input  logic              rst_n,
  input  pde_pkg::div_req_t req,
  output pde_pkg::div_rsp_t rsp
);

  localparam int W = pde_pkg::DATA_W;

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [pde_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [W-1:0]               rem_r, rem_nxt;
  logic [W-1:0]               quo_r, quo_nxt;
  logic [W-1:0]               dvs_r, dvs_nxt;
  logic                       neg_r, neg_nxt;
  logic [W:0]                 shifted;
  logic [W:0]                 diff;
  logic                       a_neg, b_neg;

  assign a_neg   = req.dividend[W-1];
  assign b_neg   = req.divisor[W-1];
  assign shifted = {rem_r, quo_r[W-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = pde_pkg::CNT_W'(W);
      rem_nxt  = '0;
      quo_nxt  = a_neg ? (W'(0) - req.dividend) : req.dividend;
      dvs_nxt  = b_neg ? (W'(0) - req.divisor) : req.divisor;
      neg_nxt  = a_neg ^ b_neg;
    end else if (busy_r) begin
      // keep remainder when the trial subtract goes negative
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == pde_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? (W'(0) - quo_r) : quo_r;

endmodule

// ===== rtl/pde_back.sv =====
// ----------------------------------------------------------------------------
// pde_back - stack execution engine
// Pops decoded commands, runs them against the operand stack (top cached
// in a register, the rest in RAM), latches the first error and emits the
// result register.
// ----------------------------------------------------------------------------
module pde_back #(
  parameter int STACK_DEPTH = pde_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  pde_pkg::cmd_t      q_rdata,
  output logic               q_rd,
  output logic               out_valid,
  input  logic               out_stall,
  output pde_pkg::out_item_t out_data
);

  localparam int W  = pde_pkg::DATA_W;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);

  pde_pkg::back_state_t state_r, state_nxt;
  logic [DW-1:0]        depth_r, depth_nxt;
  logic [1:0]           err_r, err_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [W-1:0]         tos_r, tos_nxt;
  pde_pkg::cmd_t        cmd_r, cmd_nxt;
  pde_pkg::out_item_t   out_data_r, out_data_nxt;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [W-1:0]         ram_rdata;
  logic [DW-1:0]        depth_m1, depth_m2;
  logic [W-1:0]         lhs, rhs, prod;
  pde_pkg::back_state_t head_after, cmd_after;
  pde_pkg::div_req_t    div_req;
  pde_pkg::div_rsp_t    div_rsp;

  assign depth_m1  = depth_r - DW'(1);
  assign depth_m2  = depth_r - DW'(2);
  assign ram_waddr = depth_m1[AW-1:0];
  assign ram_raddr = depth_m2[AW-1:0];

  // Second entry arrives from RAM, top from the cache register
  assign lhs  = ram_rdata;
  assign rhs  = tos_r;
  assign prod = lhs * rhs;

  assign head_after = q_rdata.last ? pde_pkg::B_EMIT : pde_pkg::B_IDLE;
  assign cmd_after  = cmd_r.last ? pde_pkg::B_EMIT : pde_pkg::B_IDLE;

  always_comb begin
    state_nxt        = state_r;
    depth_nxt        = depth_r;
    err_nxt          = err_r;
    tos_nxt          = tos_r;
    cmd_nxt          = cmd_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_data_nxt     = out_data_r;
    q_rd             = 1'b0;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = lhs;
    div_req.divisor  = rhs;
    case (state_r)
      pde_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_rd    = 1'b1;
          cmd_nxt = q_rdata;
          case (q_rdata.op)
            pde_pkg::OP_PUSH: begin
              if (depth_r == DW'(STACK_DEPTH)) begin
                // drop the digit
                if (err_r == pde_pkg::ST_OK) begin
                  err_nxt = pde_pkg::ST_OVERFLOW;
                end
              end else begin
                // spill the old top to RAM
                ram_we    = (depth_r != '0);
                tos_nxt   = {{(W-4){1'b0}}, q_rdata.digit};
                depth_nxt = depth_r + DW'(1);
              end
              state_nxt = head_after;
            end
            pde_pkg::OP_ADD, pde_pkg::OP_SUB, pde_pkg::OP_MUL, pde_pkg::OP_DIV: begin
              if (depth_r < DW'(2)) begin
                if (err_r == pde_pkg::ST_OK) begin
                  err_nxt = pde_pkg::ST_UNDERFLOW;
                end
                state_nxt = head_after;
              end else begin
                ram_re    = 1'b1;
                state_nxt = pde_pkg::B_EXEC;
              end
            end
            default: begin
              state_nxt = head_after;
            end
          endcase
        end
      end
      pde_pkg::B_EXEC: begin
        state_nxt = cmd_after;
        case (cmd_r.op)
          pde_pkg::OP_ADD: begin
            tos_nxt   = lhs + rhs;
            depth_nxt = depth_m1;
          end
          pde_pkg::OP_SUB: begin
            tos_nxt   = lhs - rhs;
            depth_nxt = depth_m1;
          end
          pde_pkg::OP_MUL: begin
            tos_nxt   = prod;
            depth_nxt = depth_m1;
          end
          pde_pkg::OP_DIV: begin
            if (rhs == '0) begin
              // leave both operands in place
              if (err_r == pde_pkg::ST_OK) begin
                err_nxt = pde_pkg::ST_DIVZERO;
              end
            end else begin
              div_req.start = 1'b1;
              state_nxt     = pde_pkg::B_DIV;
            end
          end
          default: begin
            state_nxt = cmd_after;
          end
        endcase
      end
      pde_pkg::B_DIV: begin
        if (div_rsp.done) begin
          tos_nxt   = div_rsp.quotient;
          depth_nxt = depth_m1;
          state_nxt = cmd_after;
        end
      end
      pde_pkg::B_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.value  = (depth_r != '0) ? tos_r : '0;
          out_data_nxt.status = err_r;
          depth_nxt           = '0;
          err_nxt             = pde_pkg::ST_OK;
          state_nxt           = pde_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = pde_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pde_pkg::B_IDLE;
      depth_r     <= '0;
      err_r       <= pde_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tos_r      <= tos_nxt;
    cmd_r      <= cmd_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  pde_ram #(
    .WIDTH (W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (tos_r),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  pde_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule

// ===== rtl/postfix_digit_evaluator.sv =====
// ----------------------------------------------------------------------------
// postfix_digit_evaluator - postfix (RPN) expression evaluator
// Evaluates one ASCII character per request; emits top of stack and status
// on the request marked end of expression.
// ----------------------------------------------------------------------------
//
//   Channel  | Direction | Payload            | Handshake
//   ---------+-----------+--------------------+-------------------------------
//   in_*     | input     | char_code, end     | in_valid / in_stall
//   out_*    | output    | value, status      | out_valid / out_stall
//
// Back-end steps per request: a digit or an ignored character is handled in
// the idle state; + - * add a stack RAM read and an execute step; / adds the
// RAM read, divider start, 32 divider steps and hand-back. The end-of-expression
// request then passes through the emit state, which loads the result register.
// The iterative divider sets the worst case. A two-entry command queue lets intake run ahead of execution.
// Synchronous active-low reset clears the queue, stack depth, error latch
// and result valid; no clearing pass over the stack RAM.
// A stalled result holds in the output register while further requests are
// taken into the queue; execution waits only when a new result is due.
//
module postfix_digit_evaluator #(
  parameter int STACK_DEPTH = pde_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pde_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pde_pkg::out_item_t out_data
);

  // Decoded command queue between intake and execution
  logic          q_wr, q_rd, q_full, q_empty;
  pde_pkg::cmd_t q_wdata, q_rdata;

  // Front end: decode each character request into a command
  pde_front u_front (
    .in_data  (in_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_wr     (q_wr),
    .q_wdata  (q_wdata)
  );

  pde_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // Back end: stack engine, divider and result register
  pde_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_rd      (q_rd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/pde_checker.sv =====
// ----------------------------------------------------------------------------
// pde_checker - port-level checks for the postfix digit evaluator
// Watches the request and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module pde_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input pde_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input pde_pkg::out_item_t out_data
);

  logic [3:0] pend_r, pend_nxt;
  logic       last_in, res_out;

  assign last_in = in_valid && !in_stall && in_data.end_of_expr;
  assign res_out = out_valid && !out_stall;

  // Count end-of-expression requests not yet answered
  always_comb begin
    pend_nxt = pend_r;
    if (last_in && !res_out) begin
      pend_nxt = pend_r + 4'd1;
    end else if (res_out && !last_in) begin
      pend_nxt = pend_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 4'd0)
    else $error("result without a pending end of expression");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind postfix_digit_evaluator pde_checker u_pde_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== sim/postfix_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// postfix_result_checker - result prediction for the postfix digit evaluator
// Watches both channels, evaluates every accepted request on its own operand
// stack and compares each accepted result with the oldest predicted one.
// ----------------------------------------------------------------------------
module postfix_result_checker
  import pde_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending
);

  logic [31:0] calc_stack [STACK_DEPTH];
  int          calc_depth;
  logic [1:0]  calc_err;
  out_item_t   expected_q[$];

  // first error wins until the expression ends
  task automatic latch_error(input logic [1:0] code);
    if (calc_err == ST_OK) calc_err = code;
  endtask

  // signed quotient, truncated toward zero; min / -1 wraps to min
  function automatic logic [31:0] trunc_quotient(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] q;
    mag_a = a[31] ? (32'd0 - a) : a;
    mag_b = b[31] ? (32'd0 - b) : b;
    q     = mag_a / mag_b;
    return (a[31] != b[31]) ? (32'd0 - q) : q;
  endfunction

  task automatic eval_request(input in_item_t req);
    logic [31:0] lhs;
    logic [31:0] rhs;
    logic [31:0] res;
    out_item_t   outcome;
    if (req.char_code >= CH_ZERO && req.char_code <= CH_NINE) begin
      if (calc_depth >= STACK_DEPTH) begin
        latch_error(ST_OVERFLOW);
      end else begin
        calc_stack[calc_depth] = {24'd0, req.char_code - CH_ZERO};
        calc_depth++;
      end
    end else if (req.char_code == CH_PLUS || req.char_code == CH_MINUS ||
                 req.char_code == CH_STAR || req.char_code == CH_SLASH) begin
      if (calc_depth < 2) begin
        latch_error(ST_UNDERFLOW);
      end else begin
        rhs = calc_stack[calc_depth - 1];
        lhs = calc_stack[calc_depth - 2];
        case (req.char_code)
          CH_PLUS:  res = lhs + rhs;
          CH_MINUS: res = lhs - rhs;
          CH_STAR:  res = lhs * rhs;
          default:  res = (rhs == 32'd0) ? 32'd0 : trunc_quotient(lhs, rhs);
        endcase
        if (req.char_code == CH_SLASH && rhs == 32'd0) begin
          latch_error(ST_DIVZERO);
        end else begin
          calc_depth--;
          calc_stack[calc_depth - 1] = res;
        end
      end
    end
    if (req.end_of_expr) begin
      outcome.value  = (calc_depth > 0) ? calc_stack[calc_depth - 1] : 32'd0;
      outcome.status = calc_err;
      expected_q.push_back(outcome);
      calc_depth = 0;
      calc_err   = ST_OK;
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: result with none expected, expected nothing, got value %0d status %0d",
               $time, got.value, got.status);
      fail_count = fail_count + 1;
    end else begin
      want = expected_q.pop_front();
      if (got.value !== want.value) begin
        $display("%0t: value mismatch, expected %0d, got %0d", $time, want.value, got.value);
        fail_count = fail_count + 1;
      end
      if (got.status !== want.status) begin
        $display("%0t: status mismatch, expected %0d, got %0d",
                 $time, want.status, got.status);
        fail_count = fail_count + 1;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      calc_depth = 0;
      calc_err   = ST_OK;
      fail_count = 0;
      expected_q.delete();
      pending <= 0;
    end else begin
      if (in_valid && !in_stall) eval_request(in_data);
      if (out_valid && !out_stall) check_result(out_data);
      pending <= expected_q.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - stimulus and verdict for the postfix digit evaluator
// Sends a short directed set of expressions, then randomised expressions
// (mostly well formed, some broken, some noise) in bursts against a randomly
// stalling receiver; the result checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import pde_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int REQUEST_TARGET = 700;     // digits and operators, not ignored chars
  localparam int CYCLE_LIMIT    = 400000;  // roughly ten times the slowest correct run
  localparam int DRAIN_CYCLES   = 60;      // a divide plus the result register, with margin

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        pending;
  int        cycle_count = 0;
  int        stall_left  = 0;

  // whole request stream, and the expression currently being assembled
  in_item_t   stim_q[$];
  logic [7:0] expr_buf[$];
  int         live_count = 0;

  always #(CLK_HALF) clk = ~clk;

  postfix_digit_evaluator #(.STACK_DEPTH(STACK_DEPTH_DEF)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  postfix_result_checker #(.STACK_DEPTH(STACK_DEPTH_DEF)) u_result_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  function automatic bit is_operator(input logic [7:0] c);
    return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH;
  endfunction

  // anything the evaluator acts on rather than skips
  function automatic bit is_live(input logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || is_operator(c);
  endfunction

  function automatic logic [7:0] random_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] random_operator();
    case ($urandom_range(0, 3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  // a character the evaluator ignores; fall back to a space on a hit
  function automatic logic [7:0] filler_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    return is_live(c) ? 8'h20 : c;
  endfunction

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) expr_buf.push_back(s[i]);
  endtask

  // move the assembled expression into the stream, marking its final char
  task automatic flush_expr();
    in_item_t req;
    while (expr_buf.size() != 0) begin
      req.char_code   = expr_buf.pop_front();
      req.end_of_expr = (expr_buf.size() == 0);
      if (is_live(req.char_code)) live_count++;
      stim_q.push_back(req);
    end
  endtask

  // Random postfix expression with random content. Most have a few
  // operands; some are long enough to fill the stack. A broken one has a
  // char dropped or a spare operator slipped in.
  task automatic gen_wellformed(input bit broken);
    int operands;
    int pushed;
    int depth;
    int pos;
    operands = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 18) : $urandom_range(1, 6);
    pushed   = 0;
    depth    = 0;
    while (pushed < operands || depth > 1) begin
      if ($urandom_range(0, 9) == 0) expr_buf.push_back(filler_char());
      if (depth >= 2 && (pushed == operands || $urandom_range(0, 2) == 0)) begin
        expr_buf.push_back(random_operator());
        depth--;
      end else begin
        expr_buf.push_back(random_digit());
        pushed++;
        depth++;
      end
    end
    if (broken) begin
      pos = $urandom_range(0, expr_buf.size() - 1);
      if ($urandom_range(0, 1) == 0) expr_buf.delete(pos);
      else expr_buf.insert(pos, random_operator());
    end
    flush_expr();
  endtask

  // fill the stack to or past its depth, then fold a little of it back
  task automatic gen_overflow();
    repeat ($urandom_range(STACK_DEPTH_DEF, STACK_DEPTH_DEF + 4))
      expr_buf.push_back(random_digit());
    repeat ($urandom_range(0, 3)) expr_buf.push_back(random_operator());
    flush_expr();
  endtask

  // build 8^10 * 2, which wraps to the most negative value, then divide
  // by minus one; optionally step down once more to reach the most positive
  task automatic gen_min_quotient(input bit to_max);
    queue_text("8");
    repeat (9) queue_text("8*");
    queue_text("2*01-/");
    if (to_max) queue_text("1-");
    flush_expr();
  endtask

  // arbitrary bytes, digits and operators included by chance
  task automatic gen_noise();
    repeat ($urandom_range(1, 8)) expr_buf.push_back(8'($urandom_range(0, 255)));
    flush_expr();
  endtask

  // Receiver: open stretches and stall windows of random length, in random order.
  always @(posedge clk) begin : recv_pattern
    bit hold_off;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      hold_off = ($urandom_range(0, 2) == 0);
      out_stall  <= hold_off;
      stall_left <= hold_off ? $urandom_range(0, 7) : $urandom_range(0, 40);
    end
  end

  // Watchdog: give up well beyond the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    int burst_left;

    // Directed part: empty expression on a zero byte, a single digit,
    // an all-ones byte and a space skipped, each operator, truncation of a
    // negative quotient, underflow on an empty stack, divide by zero with
    // both operands kept, and a later operator still applied after an error.
    expr_buf.push_back(8'h00);
    flush_expr();
    queue_text("9");
    flush_expr();
    expr_buf.push_back(8'hFF);
    queue_text("7 3-");
    flush_expr();
    queue_text("67*");
    flush_expr();
    queue_text("07-2/");
    flush_expr();
    queue_text("+");
    flush_expr();
    queue_text("50/");
    flush_expr();
    queue_text("10/+");
    flush_expr();

    // Random part: hit the rare shapes once, then mostly well-formed
    // expressions with broken ones and noise mixed in.
    gen_overflow();
    gen_min_quotient(1'b0);
    gen_min_quotient(1'b1);
    while (live_count < REQUEST_TARGET) begin
      case ($urandom_range(0, 19))
        0:       gen_overflow();
        1:       gen_min_quotient($urandom_range(0, 1));
        2, 3:    gen_noise();
        4, 5, 6: gen_wellformed(1'b1);
        default: gen_wellformed(1'b0);
      endcase
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Sender: bursts of requests with idle gaps between them. Hold valid
    // and payload until the request is taken; drop valid only for a gap.
    burst_left = $urandom_range(1, 20);
    while (stim_q.size() != 0) begin
      in_valid <= 1'b1;
      in_data  <= stim_q.pop_front();
      @(posedge clk);
      while (in_stall) @(posedge clk);
      burst_left--;
      if (burst_left == 0 || stim_q.size() == 0) begin
        in_valid <= 1'b0;
        if (stim_q.size() != 0) begin
          repeat ($urandom_range(1, 8)) @(posedge clk);
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(1, 20);
        end
      end
    end

    // Drain: wait for every predicted result, then allow a full divide
    // for anything stray before the verdict.
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
